// File: rtl/core/sct_pkg.sv
`default_nettype none

package sct_pkg;

    localparam int MASK_W       = 32;
    localparam int ELEMENTS_DEF = 32;
    localparam int DEPTH_DEF    = 64;
    localparam int OUT_W        = 24;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_MEMBER   = 3'd1,
        ACT_ANY_SUP  = 3'd2,
        ACT_ANY_SUB  = 3'd3,
        ACT_DROP_SUB = 3'd4,
        ACT_DROP_SUP = 3'd5,
        ACT_CLEAR    = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic dup;
        logic free_seen;
    } head_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/sct_cell.sv
`default_nettype none

module sct_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            shift_en,
    input  wire sct_pkg::entry_t word_in,
    output sct_pkg::entry_t      word_out
);
    import sct_pkg::*;

    logic              valid_reg;
    logic [MASK_W-1:0] mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= word_in.valid;
        end
    end

    // mask is don't-care while its valid bit is clear
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            mask_reg <= word_in.mask;
        end
    end

    assign word_out.valid = valid_reg;
    assign word_out.mask  = mask_reg;

endmodule

`default_nettype wire

// File: rtl/core/sct_head.sv
`default_nettype none

module sct_head #(
    parameter int DEPTH = sct_pkg::DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         clear_acc,
    input  wire logic                         step_en,
    input  wire logic                         phase_fill,
    input  wire sct_pkg::action_t             act,
    input  wire logic [sct_pkg::MASK_W-1:0]   query,
    input  wire sct_pkg::entry_t              entry_in,
    output sct_pkg::entry_t                   entry_out,
    output sct_pkg::head_flags_t              flags,
    output logic [$clog2(DEPTH+1)-1:0]        removed
);
    import sct_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    head_flags_t   flags_reg;
    head_flags_t   flags_next;
    logic          claimed_reg;
    logic          claimed_next;
    logic [CW-1:0] removed_reg;
    logic [CW-1:0] removed_next;

    logic is_eq;
    logic is_sub;
    logic is_sup;
    logic drop;

    assign is_eq  = entry_in.mask == query;
    assign is_sub = (entry_in.mask & ~query) == '0;
    assign is_sup = (query & ~entry_in.mask) == '0;

    always_comb begin
        entry_out    = entry_in;
        flags_next   = flags_reg;
        claimed_next = claimed_reg;
        removed_next = removed_reg;
        drop         = 1'b0;
        if (phase_fill) begin
            // take the first free slot of the pass
            if (!entry_in.valid && !claimed_reg) begin
                entry_out.valid = 1'b1;
                entry_out.mask  = query;
                claimed_next    = 1'b1;
            end
        end else begin
            case (act)
                ACT_INSERT: begin
                    if (entry_in.valid && is_eq) flags_next.dup = 1'b1;
                    if (!entry_in.valid) flags_next.free_seen = 1'b1;
                end
                ACT_MEMBER: begin
                    if (entry_in.valid && is_eq) flags_next.hit = 1'b1;
                end
                ACT_ANY_SUP: begin
                    if (entry_in.valid && is_sup) flags_next.hit = 1'b1;
                end
                ACT_ANY_SUB: begin
                    if (entry_in.valid && is_sub) flags_next.hit = 1'b1;
                end
                ACT_DROP_SUB: drop = entry_in.valid && is_sub;
                ACT_DROP_SUP: drop = entry_in.valid && is_sup;
                ACT_CLEAR:    drop = entry_in.valid;
                default: ;
            endcase
            if (drop) begin
                entry_out.valid = 1'b0;
                removed_next    = removed_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            claimed_reg <= 1'b0;
            removed_reg <= '0;
        end else if (clear_acc) begin
            flags_reg   <= '0;
            claimed_reg <= 1'b0;
            removed_reg <= '0;
        end else if (step_en) begin
            flags_reg   <= flags_next;
            claimed_reg <= claimed_next;
            removed_reg <= removed_next;
        end
    end

    assign flags   = flags_reg;
    assign removed = removed_reg;

endmodule

`default_nettype wire

// File: rtl/core/subset_cover_table.sv
// Flow: each accepted word makes one pass round the ring of DEPTH cells, which rotates
//   every stored entry once past the compare head per pass; an insert that stores the
//   query makes a second trip round the ring. s_tready is high only in ST_IDLE, so a new
//   request is not taken until the last one is through; a result word still waiting
//   holds the next result in ST_FINISH.
// Reset: synchronous active-low; clears all valid bits, the entry count and m_tvalid.
`default_nettype none

module subset_cover_table #(
    parameter int ELEMENTS = sct_pkg::ELEMENTS_DEF,
    parameter int DEPTH    = sct_pkg::DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [31:0] query_mask
    input  wire logic [sct_pkg::MASK_W-1:0]  s_tdata,
    // [2:0] action
    input  wire logic [2:0]                  s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] hit, [7:1] removed_count, [14:8] entry_count, [16:15] status, [23:17] zero
    output logic [sct_pkg::OUT_W-1:0]        m_tdata
);
    import sct_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [MASK_W-1:0] ELEM_MASK = (ELEMENTS >= MASK_W) ? {MASK_W{1'b1}} :
        MASK_W'((64'd1 << ELEMENTS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_FILL,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     cnt_reg;
    action_t           act_reg;
    logic [MASK_W-1:0] query_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              m_valid_reg;
    logic              out_hit_reg;
    logic              out_hit_next;
    logic [6:0]        out_removed_reg;
    logic [6:0]        out_removed_next;
    logic [6:0]        out_count_reg;
    logic [6:0]        out_count_next;
    status_t           out_status_reg;
    status_t           out_status_next;

    entry_t        ring [DEPTH];
    entry_t        head_out;
    head_flags_t   flags;
    logic [CW-1:0] removed;
    logic          shift_en;
    logic          accept;
    logic          last;
    logic          out_free;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign shift_en = (state_reg == ST_SCAN) || (state_reg == ST_FILL);
    assign last     = cnt_reg == IW'(DEPTH - 1);
    assign out_free = !m_valid_reg || m_tready;

    sct_head #(.DEPTH(DEPTH)) u_head (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_acc  (accept),
        .step_en    (shift_en),
        .phase_fill (state_reg == ST_FILL),
        .act        (act_reg),
        .query      (query_reg),
        .entry_in   (ring[DEPTH-1]),
        .entry_out  (head_out),
        .flags      (flags),
        .removed    (removed)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            sct_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .word_in  (head_out),
                .word_out (ring[g])
            );
        end else begin : g_rest
            sct_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .word_in  (ring[g-1]),
                .word_out (ring[g])
            );
        end
    end

    // result word and entry count once the passes are done
    always_comb begin
        out_hit_next     = 1'b0;
        out_removed_next = '0;
        out_status_next  = STAT_OK;
        count_next       = count_reg;
        case (act_reg)
            ACT_INSERT: begin
                if (flags.dup) begin
                    out_status_next = STAT_DUP;
                end else if (!flags.free_seen) begin
                    out_status_next = STAT_FULL;
                end else begin
                    out_hit_next = 1'b1;
                    count_next   = count_reg + CW'(1);
                end
            end
            ACT_MEMBER, ACT_ANY_SUP, ACT_ANY_SUB: begin
                out_hit_next = flags.hit;
            end
            ACT_DROP_SUB, ACT_DROP_SUP, ACT_CLEAR: begin
                out_removed_next = 7'(removed);
                count_next       = count_reg - removed;
            end
            default: ;
        endcase
        out_count_next = 7'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_FINISH) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= action_t'(s_tuser);
                        query_reg <= s_tdata & ELEM_MASK;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (last) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_CHECK;
                    end else begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                ST_CHECK: begin
                    if (act_reg == ACT_INSERT && !flags.dup && flags.free_seen) begin
                        state_reg <= ST_FILL;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FILL: begin
                    if (last) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                ST_FINISH: begin
                    // hold until the result register is free
                    if (out_free) begin
                        out_hit_reg     <= out_hit_next;
                        out_removed_reg <= out_removed_next;
                        out_status_reg  <= out_status_next;
                        out_count_reg   <= out_count_next;
                        count_reg       <= count_next;
                        m_valid_reg     <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_count_reg, out_removed_reg, out_hit_reg};

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_SCAN)
        else $error("accepted word did not start a scan");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished request produced no result word");

    a_full_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg == STAT_FULL) |-> count_reg == CW'(DEPTH))
        else $error("table full reported with free slots");

    a_fill_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILL |-> act_reg == ACT_INSERT && !flags.dup && flags.free_seen)
        else $error("fill pass without a valid insert");

endmodule

`default_nettype wire
